>>> rtl/wps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wps_pkg
// Shared constants, item types and control structs of the weighted pool
// selector.
// ----------------------------------------------------------------------------
package wps_pkg;

    localparam int POOL_DEPTH   = 16;
    localparam int ID_WIDTH     = 16;
    localparam int WEIGHT_WIDTH = 16;

    localparam int IDX_W   = $clog2(POOL_DEPTH);
    localparam int CNT_W   = $clog2(POOL_DEPTH + 1);
    localparam int TOT_W   = WEIGHT_WIDTH + IDX_W;
    localparam int ENTRY_W = ID_WIDTH + WEIGHT_WIDTH;

    // fixed field widths of the item and register interface
    localparam int RND_W       = 16;
    localparam int ENTRY_IDX_W = 4;
    localparam int PICK_IDX_W  = 4;
    localparam int MODE_W      = 2;
    localparam int POOL_CNT_W  = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 5;

    // opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_PICK  = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYBACK_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_COUNT    = 1'b1;

    // playback modes; the fourth code picks nothing
    localparam logic [MODE_W-1:0] MODE_AVOID    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WEIGHTED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SEQ      = 2'd2;

    typedef struct packed {
        logic                    opcode;
        logic [ENTRY_IDX_W-1:0]  entry_index;
        logic [ID_WIDTH-1:0]     entry_stream;
        logic [WEIGHT_WIDTH-1:0] entry_weight;
        logic [RND_W-1:0]        random_value;
    } req_item_t;

    typedef struct packed {
        logic                  pick_valid;
        logic [PICK_IDX_W-1:0] pick_index;
        logic [ID_WIDTH-1:0]   pick_stream;
    } rsp_item_t;

    typedef struct packed {
        logic                clear;
        logic                load;
        logic [IDX_W-1:0]    idx;
        logic [ID_WIDTH-1:0] stream;
    } seen_ctl_t;

endpackage
`default_nettype wire

>>> rtl/weighted_pool_selector_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_pool_selector_core
// Table of stream ids and UQ8.8 weights with roulette and round-robin picks.
// ----------------------------------------------------------------------------
// One item is in flight at a time. A write item is accepted, then its
// result goes into the output register. A weighted pick walks the active
// entries twice through the single read port of the table RAM, once to sum
// the eligible weights and once to find the target; a no-repeat pick whose
// eligible set turns out empty walks the sum pass a second time. A
// sequential pick is one pass, ending early at the chosen entry. The
// registered RAM read is hidden by issuing the next address while the
// previous entry is being processed. A result waits in the output register
// while the next item is accepted. Table entries never written read as empty
// through a per-entry valid bit, so there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module weighted_pool_selector_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // request channel
    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire wps_pkg::req_item_t              req_item,
    // result channel
    output logic                                 rsp_valid,
    input  wire logic                            rsp_stall,
    output wps_pkg::rsp_item_t                   rsp_item,
    // register writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [wps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [wps_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import wps_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SUM  = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_SEL  = 6'b001000,
        ST_SEQ  = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;

    // registers and the stream of the previous pick
    logic [MODE_W-1:0]       mode_reg, mode_next;
    logic [POOL_CNT_W-1:0]   pool_count_reg, pool_count_next;
    logic [ID_WIDTH-1:0]     last_stream_reg, last_stream_next;
    logic [POOL_DEPTH-1:0]   live_reg, live_next;

    // pick working set
    logic [RND_W-1:0]        rnd_reg, rnd_next;
    logic                    avoid_reg, avoid_next;
    logic [TOT_W-1:0]        acc_reg, acc_next;
    logic [TOT_W-1:0]        target_reg, target_next;
    logic [IDX_W-1:0]        mark_idx_reg, mark_idx_next;
    logic [ID_WIDTH-1:0]     mark_strm_reg, mark_strm_next;
    logic                    flag_reg, flag_next;
    logic                    found_reg, found_next;

    // scan pipeline: address issue, then entry processing in the following cycle
    logic [CNT_W-1:0]        iss_cnt_reg, iss_cnt_next;
    logic                    proc_vld_reg, proc_vld_next;
    logic [IDX_W-1:0]        proc_idx_reg, proc_idx_next;
    logic                    proc_live_reg, proc_live_next;

    rsp_item_t               res_reg, res_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_item_t               rsp_item_reg, rsp_item_next;

    logic                    accept;
    logic [ENTRY_IDX_W+IDX_W-1:0] wr_idx_wide;
    logic                    wr_in_range;
    logic                    ram_we;
    logic [ENTRY_W-1:0]      ram_rdata;
    logic [IDX_W-1:0]        iss_addr;
    logic                    issuing;
    logic                    scan_state;
    logic                    scan_end;
    logic [POOL_CNT_W+CNT_W-1:0] cnt_wide;
    logic [CNT_W-1:0]        active_n;
    logic [ID_WIDTH-1:0]     rd_stream;
    logic [WEIGHT_WIDTH-1:0] rd_weight;
    logic                    eligible;
    logic [TOT_W-1:0]        run_sum;
    logic [RND_W+TOT_W-1:0]  product;
    logic                    dup;
    seen_ctl_t               seen_ctl;

    function automatic rsp_item_t make_pick(logic [IDX_W-1:0] idx,
                                            logic [ID_WIDTH-1:0] stream);
        rsp_item_t                    r;
        logic [PICK_IDX_W+IDX_W-1:0]  w;
        w             = {{PICK_IDX_W{1'b0}}, idx};
        r.pick_valid  = 1'b1;
        r.pick_index  = w[PICK_IDX_W-1:0];
        r.pick_stream = stream;
        return r;
    endfunction

    // only idle takes items, so a table write can never meet a pick's read
    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // slots beyond the table are dropped
    assign wr_idx_wide = {{IDX_W{1'b0}}, req_item.entry_index};
    assign wr_in_range = (wr_idx_wide < POOL_DEPTH);
    assign ram_we      = accept && (req_item.opcode == OP_WRITE) && wr_in_range;

    // pool_count above the depth saturates
    assign cnt_wide = {{CNT_W{1'b0}}, pool_count_reg};
    assign active_n = (cnt_wide > POOL_DEPTH) ? CNT_W'(POOL_DEPTH)
                                              : cnt_wide[CNT_W-1:0];

    assign scan_state = (state_reg == ST_SUM) || (state_reg == ST_SEL)
                     || (state_reg == ST_SEQ);
    assign issuing    = scan_state && (iss_cnt_reg < active_n);
    assign scan_end   = scan_state && (iss_cnt_reg == active_n) && !proc_vld_reg;
    assign iss_addr   = iss_cnt_reg[IDX_W-1:0];

    wps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (POOL_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx_wide[IDX_W-1:0]),
        .wdata ({req_item.entry_stream, req_item.entry_weight}),
        .re    (issuing),
        .raddr (iss_addr),
        .rdata (ram_rdata)
    );

    // an entry not yet written reads as empty with zero weight
    assign rd_stream = proc_live_reg ? ram_rdata[ENTRY_W-1:WEIGHT_WIDTH] : '0;
    assign rd_weight = proc_live_reg ? ram_rdata[WEIGHT_WIDTH-1:0] : '0;

    assign eligible = (rd_stream != '0) && (rd_weight != '0)
                   && !(avoid_reg && (rd_stream == last_stream_reg));
    assign run_sum  = acc_reg + TOT_W'(rd_weight);
    assign product  = (RND_W+TOT_W)'(rnd_reg) * (RND_W+TOT_W)'(acc_reg);

    wps_seen u_seen (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (seen_ctl),
        .probe (rd_stream),
        .match (dup)
    );

    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        pool_count_next  = pool_count_reg;
        last_stream_next = last_stream_reg;
        live_next        = live_reg;
        rnd_next         = rnd_reg;
        avoid_next       = avoid_reg;
        acc_next         = acc_reg;
        target_next      = target_reg;
        mark_idx_next    = mark_idx_reg;
        mark_strm_next   = mark_strm_reg;
        flag_next        = flag_reg;
        found_next       = found_reg;
        res_next         = res_reg;
        rsp_item_next    = rsp_item_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;

        iss_cnt_next     = issuing ? iss_cnt_reg + CNT_W'(1) : iss_cnt_reg;
        proc_vld_next    = issuing;
        proc_idx_next    = issuing ? iss_addr : proc_idx_reg;
        proc_live_next   = live_reg[iss_addr];

        seen_ctl         = '0;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PLAYBACK_MODE: mode_next       = cfg_data[MODE_W-1:0];
                CFG_POOL_COUNT:    pool_count_next = cfg_data[POOL_CNT_W-1:0];
            endcase
        end

        if (ram_we)
        begin
            live_next[wr_idx_wide[IDX_W-1:0]] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next     = '0;
                    rnd_next     = req_item.random_value;
                    iss_cnt_next = '0;
                    acc_next     = '0;
                    flag_next    = 1'b0;
                    found_next   = 1'b0;
                    if (req_item.opcode == OP_WRITE)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        unique case (mode_reg)
                            MODE_AVOID:
                            begin
                                avoid_next = 1'b1;
                                state_next = ST_SUM;
                            end
                            MODE_WEIGHTED:
                            begin
                                avoid_next = 1'b0;
                                state_next = ST_SUM;
                            end
                            MODE_SEQ:
                            begin
                                seen_ctl.clear = 1'b1;
                                state_next     = ST_SEQ;
                            end
                            default:
                            begin
                                state_next = ST_EMIT;
                            end
                        endcase
                    end
                end
            end

            ST_SUM:
            begin
                if (proc_vld_reg && eligible)
                begin
                    acc_next       = run_sum;
                    flag_next      = 1'b1;
                    mark_idx_next  = proc_idx_reg;
                    mark_strm_next = rd_stream;
                end
                else if (scan_end)
                begin
                    if (flag_reg)
                    begin
                        state_next = ST_MUL;
                    end
                    else if (avoid_reg)
                    begin
                        // nothing left once repeats are barred: plain roulette
                        avoid_next   = 1'b0;
                        iss_cnt_next = '0;
                        acc_next     = '0;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_MUL:
            begin
                target_next  = product[RND_W+TOT_W-1:RND_W];
                acc_next     = '0;
                iss_cnt_next = '0;
                state_next   = ST_SEL;
            end

            ST_SEL:
            begin
                if (proc_vld_reg && eligible)
                begin
                    acc_next = run_sum;
                    if (run_sum > target_reg)
                    begin
                        res_next         = make_pick(proc_idx_reg, rd_stream);
                        last_stream_next = rd_stream;
                        state_next       = ST_EMIT;
                    end
                end
                else if (scan_end)
                begin
                    // target never passed: last eligible entry
                    res_next         = make_pick(mark_idx_reg, mark_strm_reg);
                    last_stream_next = mark_strm_reg;
                    state_next       = ST_EMIT;
                end
            end

            ST_SEQ:
            begin
                if (proc_vld_reg)
                begin
                    seen_ctl.load   = 1'b1;
                    seen_ctl.idx    = proc_idx_reg;
                    seen_ctl.stream = rd_stream;
                    if ((rd_stream != '0) && !dup)
                    begin
                        if (!flag_reg)
                        begin
                            flag_next      = 1'b1;
                            mark_idx_next  = proc_idx_reg;
                            mark_strm_next = rd_stream;
                        end
                        if (found_reg)
                        begin
                            res_next         = make_pick(proc_idx_reg, rd_stream);
                            last_stream_next = rd_stream;
                            state_next       = ST_EMIT;
                        end
                        else if (rd_stream == last_stream_reg)
                        begin
                            found_next = 1'b1;
                        end
                    end
                end
                else if (scan_end)
                begin
                    // wrap to the first distinct entry
                    if (flag_reg)
                    begin
                        res_next         = make_pick(mark_idx_reg, mark_strm_reg);
                        last_stream_next = mark_strm_reg;
                    end
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_item_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            mode_reg        <= '0;
            pool_count_reg  <= '0;
            last_stream_reg <= '0;
            live_reg        <= '0;
            rsp_valid_reg   <= 1'b0;
            proc_vld_reg    <= 1'b0;
            iss_cnt_reg     <= '0;
            flag_reg        <= 1'b0;
            found_reg       <= 1'b0;
            avoid_reg       <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            pool_count_reg  <= pool_count_next;
            last_stream_reg <= last_stream_next;
            live_reg        <= live_next;
            rsp_valid_reg   <= rsp_valid_next;
            proc_vld_reg    <= proc_vld_next;
            iss_cnt_reg     <= iss_cnt_next;
            flag_reg        <= flag_next;
            found_reg       <= found_next;
            avoid_reg       <= avoid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_reg       <= rnd_next;
        acc_reg       <= acc_next;
        target_reg    <= target_next;
        mark_idx_reg  <= mark_idx_next;
        mark_strm_reg <= mark_strm_next;
        proc_idx_reg  <= proc_idx_next;
        proc_live_reg <= proc_live_next;
        res_reg       <= res_next;
        rsp_item_reg  <= rsp_item_next;
    end

endmodule
`default_nettype wire

>>> rtl/wps_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/wps_seen.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wps_seen
// Stream ids already passed in a sequential scan; flags a later duplicate.
// ----------------------------------------------------------------------------
module wps_seen (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire wps_pkg::seen_ctl_t           ctl,
    input  wire logic [wps_pkg::ID_WIDTH-1:0] probe,
    output logic                              match
);
    import wps_pkg::*;

    logic [ID_WIDTH-1:0]   id_reg [POOL_DEPTH];
    logic [POOL_DEPTH-1:0] vld_reg;
    logic [POOL_DEPTH-1:0] vld_next;
    logic [POOL_DEPTH-1:0] hit;

    always_comb
    begin
        vld_next = vld_reg;
        if (ctl.clear)
        begin
            vld_next = '0;
        end
        else if (ctl.load)
        begin
            vld_next[ctl.idx] = 1'b1;
        end
    end

    always_comb
    begin
        for (int k = 0; k < POOL_DEPTH; k++)
        begin
            hit[k] = vld_reg[k] && (id_reg[k] == probe);
        end
    end

    assign match = |hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            id_reg[ctl.idx] <= ctl.stream;
        end
    end

endmodule
`default_nettype wire
